// ----- src/fxlms_noise_canceller_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the filtered-x LMS noise canceller
// Concurrent assertion wrappers clocked on clk; one form is gated by reset.
// ----------------------------------------------------------------------------
`ifndef FXLMS_NOISE_CANCELLER_MACROS_SVH
`define FXLMS_NOISE_CANCELLER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only while the block is out of reset.
`define FXNC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fxlms_noise_canceller: assertion failed");

// Checked at every clock edge, during reset as well.
`define FXNC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fxlms_noise_canceller: reset assertion failed");

`else

`define FXNC_ASSERT(lbl, prop)
`define FXNC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- src/fxnc_pkg.sv -----
// ----------------------------------------------------------------------------
// fxnc_pkg
// Constants, register indexes and the fixed secondary-path model.
// ----------------------------------------------------------------------------
package fxnc_pkg;

  // Register map.
  localparam int  CFG_AW        = 3;
  localparam logic REG_STEP_SIZE = 1'b0;
  localparam logic [15:0] STEP_RESET = 16'd6554;

  // Fixed-point formats.
  localparam int WEIGHT_W    = 24;
  localparam int WEIGHT_FRAC = 20;
  localparam int FX_W        = 16;
  localparam int STEP_W      = 16;

  // Shared multiplier operand widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic signed [WEIGHT_W-1:0] W_MAX  = 24'sh7FFFFF;
  localparam logic signed [WEIGHT_W-1:0] W_MIN  = -24'sh800000;
  localparam logic signed [FX_W-1:0]     FX_MAX = 16'sh7FFF;
  localparam logic signed [FX_W-1:0]     FX_MIN = -16'sh8000;

  // Secondary-path model in Q1.15; taps past the seventh are zero.
  localparam int PATH_NZ = 7;
  localparam logic signed [FX_W-1:0] PATH_COEFF [PATH_NZ] = '{
    16'sd82, 16'sd2048, 16'sd4096, 16'sd8192, 16'sd4096, 16'sd2048, 16'sd82
  };

  function automatic logic signed [FX_W-1:0] path_coeff(input logic [8:0] idx);
    logic signed [FX_W-1:0] c;
    c = '0;
    if (idx < 9'(PATH_NZ)) begin
      c = PATH_COEFF[idx[2:0]];
    end
    return c;
  endfunction

endpackage

// ----- src/fxnc_stream_if.sv -----
// ----------------------------------------------------------------------------
// fxnc stream interfaces
// Valid/ready channels for sample items and drive items.
// ----------------------------------------------------------------------------
interface fxnc_in_if #(parameter int SAMPLE_BITS = 12) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] ref_sample;
  logic [SAMPLE_BITS-1:0] error_sample;

  modport source (output valid, output ref_sample, output error_sample, input ready);
  modport sink   (input valid, input ref_sample, input error_sample, output ready);
endinterface

interface fxnc_out_if #(parameter int SAMPLE_BITS = 12) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

// ----- src/fxlms_noise_canceller.sv -----
// ----------------------------------------------------------------------------
// fxlms_noise_canceller
// Filtered-x LMS adaptive FIR for active noise cancellation.
// ----------------------------------------------------------------------------
// Each sample item runs through one shared 33x17 multiplier in four passes:
// the adaptive FIR over ADAPT_TAPS weights, the secondary-path filter over
// PATH_TAPS taps, one product of step size and error, and the weight update
// over ADAPT_TAPS taps. The multiplier takes one product per cycle. The input
// is not ready while an item is in the block, so a new item is taken only
// after the weight update of the last one has finished. The drive item is
// registered after the FIR pass and may wait at the output while the rest of
// the item proceeds; the next item then stalls at the end of its own FIR
// pass until the drive register is free. After reset, a clearing pass zeroes
// the history and weight memories before the first item is taken. The step
// size is used in the error product of the item in progress, so the user
// must write the step size register only while no item is in flight; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "fxlms_noise_canceller_macros.svh"

module fxlms_noise_canceller #(
  parameter int ADAPT_TAPS  = 16,
  parameter int PATH_TAPS   = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  fxnc_in_if.sink                      in_ch,
  fxnc_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fxnc_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import fxnc_pkg::*;

  localparam int HIST_LEN = (ADAPT_TAPS > PATH_TAPS) ? ADAPT_TAPS : PATH_TAPS;
  localparam int HW       = $clog2(HIST_LEN);
  localparam int AW       = $clog2(ADAPT_TAPS);
  localparam int CNT_W    = $clog2(HIST_LEN + 1);
  localparam int FRAC     = SAMPLE_BITS - 1;
  localparam int UPD_SH   = 11 + FRAC;
  localparam int ACC_W    = WEIGHT_W + SAMPLE_BITS + $clog2(ADAPT_TAPS) + 1;

  localparam logic signed [ACC_W-1:0]  HALF_Y   = ACC_W'(1) << (WEIGHT_FRAC - 1);
  localparam logic signed [ACC_W-1:0]  MID_Y    = ACC_W'(1) << FRAC;
  localparam logic signed [ACC_W-1:0]  TOP_Y    = (ACC_W'(1) << SAMPLE_BITS) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0]  HALF_FX  = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [PROD_W-1:0] HALF_UPD = PROD_W'(1) << (UPD_SH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIR,
    ST_FIR_END,
    ST_PATH,
    ST_PATH_END,
    ST_ME,
    ST_UPD
  } state_t;

  // Memories.
  logic signed [SAMPLE_BITS-1:0] ref_mem [HIST_LEN];
  logic signed [FX_W-1:0]        fx_mem  [HIST_LEN];
  logic signed [WEIGHT_W-1:0]    w_mem   [ADAPT_TAPS];

  // Control state.
  state_t                        state_r;
  logic [CNT_W-1:0]              clr_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [HW-1:0]                 pos_r;
  logic [HW-1:0]                 rp_r;
  logic                          s1_v_r;
  logic                          s2_v_r;
  logic                          out_valid_r;
  logic [STEP_W-1:0]             step_r;

  // Datapath registers.
  logic [CNT_W-1:0]              s1_k_r;
  logic [CNT_W-1:0]              s2_k_r;
  logic signed [SAMPLE_BITS-1:0] x_q_r;
  logic signed [FX_W-1:0]        fx_q_r;
  logic signed [WEIGHT_W-1:0]    w_q_r;
  logic signed [WEIGHT_W-1:0]    w_d_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [MUL_A_W-1:0]     me_r;
  logic signed [SAMPLE_BITS-1:0] e_r;
  logic [SAMPLE_BITS-1:0]        drive_r;

  // Combinational signals.
  logic                          accept;
  logic                          cfg_we;
  logic [CNT_W-1:0]              lim;
  logic                          phase;
  logic                          issue;
  logic                          seq_done;
  logic [HW-1:0]                 rp_dec;
  logic [HW-1:0]                 pos_inc;
  logic signed [SAMPLE_BITS-1:0] x_in;
  logic signed [SAMPLE_BITS-1:0] e_in;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [ACC_W-1:0]       y_rnd;
  logic signed [ACC_W-1:0]       y_off;
  logic [SAMPLE_BITS-1:0]        drive_nxt;
  logic signed [ACC_W-1:0]       fx_rnd;
  logic signed [FX_W-1:0]        fx_nxt;
  logic signed [PROD_W-1:0]      dw;
  logic signed [PROD_W-1:0]      w_sum;
  logic signed [WEIGHT_W-1:0]    w_nxt;

  logic                          ref_we;
  logic [HW-1:0]                 ref_wa;
  logic signed [SAMPLE_BITS-1:0] ref_wd;
  logic                          fx_we;
  logic [HW-1:0]                 fx_wa;
  logic signed [FX_W-1:0]        fx_wd;
  logic                          w_we;
  logic [AW-1:0]                 w_wa;
  logic signed [WEIGHT_W-1:0]    w_wd;

  // Handshakes and the register port.
  assign in_ch.ready        = (state_r == ST_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_value = drive_r;
  assign pready             = 1'b1;
  assign cfg_we             = psel && penable && pwrite
                              && (paddr[CFG_AW-1:2] == REG_STEP_SIZE);
  assign prdata             = (paddr[CFG_AW-1:2] == REG_STEP_SIZE)
                              ? {16'b0, step_r} : 32'b0;

  // Offset binary to two's complement by flipping the top bit.
  assign x_in = {~in_ch.ref_sample[SAMPLE_BITS-1], in_ch.ref_sample[SAMPLE_BITS-2:0]};
  assign e_in = {~in_ch.error_sample[SAMPLE_BITS-1],
                 in_ch.error_sample[SAMPLE_BITS-2:0]};

  assign rp_dec  = (rp_r == '0) ? HW'(HIST_LEN - 1) : rp_r - 1'b1;
  assign pos_inc = (pos_r == HW'(HIST_LEN - 1)) ? '0 : pos_r + 1'b1;

  always_comb begin
    unique case (state_r)
      ST_FIR, ST_UPD: lim = CNT_W'(ADAPT_TAPS);
      ST_PATH:        lim = CNT_W'(PATH_TAPS);
      default:        lim = CNT_W'(1);
    endcase
  end

  assign phase    = (state_r == ST_FIR) || (state_r == ST_PATH)
                    || (state_r == ST_ME) || (state_r == ST_UPD);
  assign issue    = phase && (cnt_r != lim);
  assign seq_done = phase && (cnt_r == lim) && !s1_v_r && !s2_v_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_r)
      ST_FIR: begin
        mul_a = MUL_A_W'(w_q_r);
        mul_b = MUL_B_W'(x_q_r);
      end
      ST_PATH: begin
        mul_a = MUL_A_W'(path_coeff(9'(s1_k_r)));
        mul_b = MUL_B_W'(x_q_r);
      end
      ST_ME: begin
        mul_a = MUL_A_W'(e_r);
        mul_b = $signed({1'b0, step_r});
      end
      ST_UPD: begin
        mul_a = me_r;
        mul_b = MUL_B_W'(fx_q_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounding and saturation of the three narrowed results.
  always_comb begin
    y_rnd = (acc_r + HALF_Y) >>> WEIGHT_FRAC;
    y_off = y_rnd + MID_Y;
    if (y_off < 0) begin
      drive_nxt = '0;
    end else if (y_off > TOP_Y) begin
      drive_nxt = '1;
    end else begin
      drive_nxt = y_off[SAMPLE_BITS-1:0];
    end

    fx_rnd = (acc_r + HALF_FX) >>> FRAC;
    if (fx_rnd > ACC_W'(FX_MAX)) begin
      fx_nxt = FX_MAX;
    end else if (fx_rnd < ACC_W'(FX_MIN)) begin
      fx_nxt = FX_MIN;
    end else begin
      fx_nxt = fx_rnd[FX_W-1:0];
    end

    dw    = (prod_r + HALF_UPD) >>> UPD_SH;
    w_sum = PROD_W'(w_d_r) + dw;
    if (w_sum > PROD_W'(W_MAX)) begin
      w_nxt = W_MAX;
    end else if (w_sum < PROD_W'(W_MIN)) begin
      w_nxt = W_MIN;
    end else begin
      w_nxt = w_sum[WEIGHT_W-1:0];
    end
  end

  // Memory write ports.
  always_comb begin
    ref_we = 1'b0;
    ref_wa = pos_r;
    ref_wd = x_in;
    fx_we  = 1'b0;
    fx_wa  = pos_r;
    fx_wd  = fx_nxt;
    w_we   = 1'b0;
    w_wa   = s2_k_r[AW-1:0];
    w_wd   = w_nxt;
    if (state_r == ST_CLEAR) begin
      ref_we = 1'b1;
      ref_wa = clr_r[HW-1:0];
      ref_wd = '0;
      fx_we  = 1'b1;
      fx_wa  = clr_r[HW-1:0];
      fx_wd  = '0;
      w_we   = (clr_r < CNT_W'(ADAPT_TAPS));
      w_wa   = clr_r[AW-1:0];
      w_wd   = '0;
    end else begin
      ref_we = accept;
      fx_we  = (state_r == ST_PATH_END);
      w_we   = s2_v_r && (state_r == ST_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_wa] <= ref_wd;
    end
    x_q_r <= ref_mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (fx_we) begin
      fx_mem[fx_wa] <= fx_wd;
    end
    fx_q_r <= fx_mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_wa] <= w_wd;
    end
    w_q_r <= w_mem[cnt_r[AW-1:0]];
  end

  // Sequencer, multiply-accumulate pipeline and output register.
  always_ff @(posedge clk) begin
    s1_k_r <= cnt_r;
    s2_k_r <= s1_k_r;
    prod_r <= mul_a * mul_b;
    w_d_r  <= w_q_r;
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      pos_r       <= '0;
      rp_r        <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= STEP_RESET;
    end else begin
      if (cfg_we) begin
        step_r <= pwdata[STEP_W-1:0];
      end
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      if (issue) begin
        cnt_r <= cnt_r + 1'b1;
        rp_r  <= rp_dec;
      end
      if (s2_v_r) begin
        if (state_r == ST_FIR || state_r == ST_PATH) begin
          acc_r <= acc_r + ACC_W'(prod_r);
        end else if (state_r == ST_ME) begin
          me_r <= prod_r[MUL_A_W-1:0];
        end
      end
      if (out_valid_r && out_ch.ready && (state_r != ST_FIR_END)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CNT_W'(HIST_LEN - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_ch.valid) begin
            e_r     <= e_in;
            cnt_r   <= '0;
            rp_r    <= pos_r;
            acc_r   <= '0;
            state_r <= ST_FIR;
          end
        end
        ST_FIR: begin
          if (seq_done) begin
            state_r <= ST_FIR_END;
          end
        end
        ST_FIR_END: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            drive_r     <= drive_nxt;
            acc_r       <= '0;
            cnt_r       <= '0;
            rp_r        <= pos_r;
            state_r     <= ST_PATH;
          end
        end
        ST_PATH: begin
          if (seq_done) begin
            state_r <= ST_PATH_END;
          end
        end
        ST_PATH_END: begin
          cnt_r   <= '0;
          state_r <= ST_ME;
        end
        ST_ME: begin
          if (seq_done) begin
            cnt_r   <= '0;
            rp_r    <= pos_r;
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (seq_done) begin
            pos_r   <= pos_inc;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
    end
  end

  `FXNC_ASSERT_ALWAYS(a_reset_state, !rst_n |=> (state_r == ST_CLEAR) && !out_valid_r)
  `FXNC_ASSERT(a_accept_starts_fir, accept |=> state_r == ST_FIR)
  `FXNC_ASSERT(a_count_bounded, phase |-> cnt_r <= lim)
  `FXNC_ASSERT(a_drained_at_end, (state_r == ST_FIR_END || state_r == ST_PATH_END) |-> !s1_v_r && !s2_v_r)
  `FXNC_ASSERT(a_drive_from_fir, $rose(out_valid_r) |-> $past(state_r) == ST_FIR_END)

endmodule

// ----- tb/fxnc_drive_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fxnc_drive_checker
// Watches the sample, drive and register ports of the noise canceller. It
// keeps its own filtered-x LMS state, predicts the drive code of every
// accepted sample item and compares it with the drive items in order.
// Step size writes are tracked and step size reads are compared.
// ----------------------------------------------------------------------------
module fxnc_drive_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  fxnc_in_if                           in_ch,
  fxnc_out_if                          out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fxnc_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  input  logic [31:0]                  prdata,
  input  logic                         pready,
  output int                           mismatches,
  output int                           outstanding
);
  import fxnc_pkg::*;

  localparam int TAPS = 16;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_AW-1:0] STEP_ADDR = {REG_STEP_SIZE, 2'b00};
  localparam logic [STEP_W-1:0] STEP_AT_RESET = 16'd6554;
  localparam longint DRIVE_TOP = 4095;
  localparam longint FX_TOP = 32767;
  localparam longint FX_BOTTOM = -32768;
  localparam longint WEIGHT_TOP = 8388607;
  localparam longint WEIGHT_BOTTOM = -8388608;
  localparam longint SECONDARY_PATH [TAPS] = '{
    82, 2048, 4096, 8192, 4096, 2048, 82, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  logic signed [11:0]         ref_hist [TAPS];
  logic signed [FX_W-1:0]     fx_hist [TAPS];
  logic signed [WEIGHT_W-1:0] weights [TAPS];
  logic [3:0]                 wr_pos;
  logic [STEP_W-1:0]          step_q;
  logic [11:0]                drive_expected [$];
  int                         fail_count;
  int                         pending_count;

  assign mismatches  = fail_count;
  assign outstanding = pending_count;

  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Runs one sample pair through the canceller state and returns the drive.
  function automatic logic [11:0] predict_drive(input logic [11:0] ref_code,
                                                input logic [11:0] err_code);
    logic signed [11:0] x;
    logic signed [11:0] e;
    logic [3:0]         idx;
    longint             acc;
    longint             me;
    longint             dw;
    longint             y;
    x = ref_code ^ 12'h800;
    e = err_code ^ 12'h800;
    ref_hist[wr_pos] = x;

    acc = 0;
    for (int k = 0; k < TAPS; k++) begin
      idx = wr_pos - 4'(k);
      acc += longint'(weights[k]) * longint'(ref_hist[idx]);
    end
    y = clamp(round_shift(acc, WEIGHT_FRAC) + 2048, 0, DRIVE_TOP);

    acc = 0;
    for (int k = 0; k < TAPS; k++) begin
      idx = wr_pos - 4'(k);
      acc += SECONDARY_PATH[k] * longint'(ref_hist[idx]);
    end
    fx_hist[wr_pos] = FX_W'(clamp(round_shift(acc, 11), FX_BOTTOM, FX_TOP));

    me = longint'(step_q) * longint'(e);
    for (int k = 0; k < TAPS; k++) begin
      idx = wr_pos - 4'(k);
      dw = round_shift(me * longint'(fx_hist[idx]), 22);
      weights[k] = WEIGHT_W'(clamp(longint'(weights[k]) + dw, WEIGHT_BOTTOM, WEIGHT_TOP));
    end

    wr_pos = wr_pos + 4'd1;
    return 12'(y);
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    if (fail_count < REPORT_LIMIT) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAPS; k++) begin
        ref_hist[k] = '0;
        fx_hist[k]  = '0;
        weights[k]  = '0;
      end
      wr_pos = '0;
      step_q = STEP_AT_RESET;
      drive_expected.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (drive_expected.size() == 0) begin
          note_mismatch("unexpected drive item", -1, out_ch.drive_value);
        end else if (drive_expected[0] != out_ch.drive_value) begin
          note_mismatch("drive_value", drive_expected[0], out_ch.drive_value);
          void'(drive_expected.pop_front());
        end else begin
          void'(drive_expected.pop_front());
        end
      end
      if (psel && penable && pready && paddr == STEP_ADDR) begin
        if (pwrite) begin
          step_q = pwdata[STEP_W-1:0];
        end else if (prdata != {16'b0, step_q}) begin
          note_mismatch("step_size read", {16'b0, step_q}, prdata);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        drive_expected.push_back(predict_drive(in_ch.ref_sample, in_ch.error_sample));
      end
    end
    pending_count = drive_expected.size();
  end

endmodule

// ----- tb/tb_fxlms_noise_canceller.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fxlms_noise_canceller
// Drives sample items and step size settings into the noise canceller with
// random gaps on both channels, a long output hold-off and a full drain
// pause. Checking is done by fxnc_drive_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_fxlms_noise_canceller;
  import fxnc_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD = 400;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 150;
  localparam logic [CFG_AW-1:0] STEP_ADDR = {REG_STEP_SIZE, 2'b00};
  localparam logic [CFG_AW-1:0] UNMAPPED_ADDR = {~REG_STEP_SIZE, 2'b00};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                mismatches;
  int                outstanding;
  bit                idle_on = 1'b1;
  int                hold_cycles = 0;

  fxnc_in_if  #(.SAMPLE_BITS(12)) in_ch ();
  fxnc_out_if #(.SAMPLE_BITS(12)) out_ch ();

  fxlms_noise_canceller u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fxnc_drive_checker u_drive_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  function automatic logic [11:0] sample_code();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'd2048;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic offer_samples(input logic [11:0] ref_code, input logic [11:0] err_code);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.ref_sample   <= ref_code;
    in_ch.error_sample <= err_code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_block();
    in_ch.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_step(input logic [15:0] step);
    drain_block();
    cfg_access(1'b1, STEP_ADDR, {16'($urandom()), step});
    cfg_access(1'b0, STEP_ADDR, '0);
  endtask

  // Output side: a random stall before each drive item, or a long hold-off on request.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    logic [15:0] phase_steps [PHASES];
    in_ch.valid        = 1'b0;
    in_ch.ref_sample   = '0;
    in_ch.error_sample = '0;
    phase_steps = '{16'd6554, 16'hFFFF, 16'd0, 16'($urandom_range(2, 65534)), 16'd1,
                    16'($urandom_range(2, 65534))};

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    cfg_access(1'b0, STEP_ADDR, '0);

    // Reset step size: zero, full scale and mixed extremes.
    offer_samples(12'd2048, 12'd2048);
    offer_samples(12'd4095, 12'd4095);
    offer_samples(12'd0, 12'd0);
    offer_samples(12'd4095, 12'd0);
    offer_samples(12'd0, 12'd4095);

    // Largest step: drive the weights into saturation, then the drive both ways.
    set_step(16'hFFFF);
    cfg_access(1'b1, UNMAPPED_ADDR, $urandom());
    cfg_access(1'b0, STEP_ADDR, '0);
    repeat (14) offer_samples(12'd0, 12'd0);
    repeat (2) offer_samples(12'd4095, 12'd2048);
    offer_samples(12'd0, 12'd2048);

    // Zero step: the weights must hold still.
    set_step(16'd0);
    offer_samples(12'd4095, 12'd0);
    offer_samples(12'd0, 12'd4095);
    offer_samples(12'd2048, 12'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_step(phase_steps[ph]);
      idle_on = (ph != 3);
      if (ph == 1) hold_cycles = LONG_HOLD;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) begin
          in_ch.valid <= 1'b0;
          wait (outstanding == 0);
          @(negedge clk);
        end
        offer_samples(sample_code(), sample_code());
      end
    end

    in_ch.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/fxnc_pkg.sv
src/fxnc_stream_if.sv
src/fxlms_noise_canceller.sv
tb/fxnc_drive_checker.sv
tb/tb_fxlms_noise_canceller.sv
